// ===== rtl/btbd_pkg.sv =====
// Shared types, constants and arithmetic helpers for the beat detector.
package btbd_pkg;

  localparam int RING_DEPTH = 64;
  localparam int RING_AW    = $clog2(RING_DEPTH);
  localparam int RING_CW    = $clog2(RING_DEPTH + 1);

  localparam int PADDR_W = 4;

  typedef logic signed [15:0] smp_t;
  typedef logic signed [23:0] lvl_t;
  typedef logic signed [25:0] op_t;
  typedef logic signed [26:0] rnd_t;
  typedef logic signed [27:0] sum_t;
  typedef logic signed [42:0] prod_t;
  typedef logic [RING_AW-1:0] ptr_t;

  typedef logic [1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_FILTER_GAIN = 2'd0;
  localparam cfg_idx_t CFG_PEAK_DECAY  = 2'd1;
  localparam cfg_idx_t CFG_PEAK_RATIO  = 2'd2;

  localparam logic [15:0] FILTER_GAIN_RST = 16'd39322;
  localparam logic [15:0] PEAK_DECAY_RST  = 16'd61604;
  localparam logic [15:0] PEAK_RATIO_RST  = 16'd9830;

  localparam lvl_t LVL_MAX = 24'sh7FFFFF;
  localparam lvl_t LVL_MIN = 24'sh800000;

  typedef struct packed {
    logic [15:0] filter_gain;
    logic [15:0] peak_decay;
    logic [15:0] peak_ratio;
  } cfg_t;

  // Round a Q16 product to nearest, halves toward plus infinity.
  function automatic rnd_t round_q16(prod_t p);
    prod_t s;
    s = p + prod_t'(32768);
    return rnd_t'(s[42:16]);
  endfunction

  function automatic lvl_t sat24(sum_t v);
    if (v > sum_t'(LVL_MAX)) begin
      return LVL_MAX;
    end else if (v < sum_t'(LVL_MIN)) begin
      return LVL_MIN;
    end
    return lvl_t'(v);
  endfunction

endpackage

// ===== rtl/bass_treble_beat_detector_top.sv =====
// Top level of the bass/treble beat detector: sequencer, ring, shared multiplier, registers.
// Each accepted sample is stored in a RING_DEPTH-entry ring, then both filters are rerun
// over the ring from oldest to newest and the results are tested against decaying peak
// trackers. The single shared multiplier forms the bass and the treble product for every
// ring entry after the oldest and then four peak products, so a new sample is accepted
// only once the previous one has been through the whole sequence.
// in_ready_o is high only while the sequencer is idle; a finished result waits in the
// output register while the next sample is accepted, and the sequencer holds at the end
// only when the previous result has not been taken yet. Unwritten ring entries read as zero
// through a fill count, so there is no clearing pass after reset.
module bass_treble_beat_detector_top
  import btbd_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  smp_t               sample_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               bass_beat_o,
  output logic               treble_beat_o,
  output lvl_t               bass_level_o,
  output lvl_t               treble_level_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  typedef enum logic [3:0] {
    S_IDLE, S_SEED_RD, S_SEED, S_LD, S_MB, S_MT, S_TFIN, S_PD, S_PR, S_PM, S_PC
  } state_e;

  state_e      state_q;
  ptr_t        wp_q, rp_q, idx_q;
  lvl_t        b_q, t_q, bp_q, tp_q;
  smp_t        cur_q, prev_q;
  op_t         op_q;
  logic        tpend_q, chan_q, bwas_q, twas_q, bbeat_q;
  logic        out_valid_q, out_bb_q, out_tb_q;
  lvl_t        out_bl_q, out_tl_q;

  cfg_t        cfg;
  smp_t        rd_data;
  prod_t       prod;
  logic [15:0] coef;
  logic        ring_we, ring_re;
  ptr_t        wp_nxt;
  rnd_t        prod_rnd;
  lvl_t        lvl_sel;
  logic        pk;

  function automatic ptr_t ptr_inc(ptr_t p);
    if (p == RING_AW'(RING_DEPTH - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  btbd_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign ring_we = (state_q == S_IDLE) && in_valid_i;
  assign ring_re = (state_q == S_SEED_RD) || (state_q == S_SEED) || (state_q == S_MB);

  btbd_ring u_ring (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (ring_we),
    .waddr_i (wp_q),
    .wdata_i (sample_i),
    .re_i    (ring_re),
    .raddr_i (rp_q),
    .rdata_o (rd_data)
  );

  always_comb begin
    unique case (state_q)
      S_PD:       coef = cfg.peak_decay;
      S_PM, S_PC: coef = cfg.peak_ratio;
      default:    coef = cfg.filter_gain;
    endcase
  end

  btbd_mul u_mul (
    .clk_i (clk_i),
    .a_i   (op_q),
    .k_i   (coef),
    .p_o   (prod)
  );

  assign wp_nxt   = ptr_inc(wp_q);
  assign prod_rnd = round_q16(prod);
  assign lvl_sel  = chan_q ? t_q : b_q;
  // Exact peak test: level*4096 against decayed peak times ratio.
  assign pk       = (prod_t'(lvl_sel) <<< 12) > prod;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      wp_q        <= '0;
      rp_q        <= '0;
      idx_q       <= '0;
      b_q         <= '0;
      t_q         <= '0;
      bp_q        <= '0;
      tp_q        <= '0;
      cur_q       <= '0;
      prev_q      <= '0;
      op_q        <= '0;
      tpend_q     <= 1'b0;
      chan_q      <= 1'b0;
      bwas_q      <= 1'b0;
      twas_q      <= 1'b0;
      bbeat_q     <= 1'b0;
      out_valid_q <= 1'b0;
      out_bb_q    <= 1'b0;
      out_tb_q    <= 1'b0;
      out_bl_q    <= '0;
      out_tl_q    <= '0;
    end else begin
      // Drop valid on acceptance unless a new result is loaded in the same cycle.
      if (out_valid_q && out_ready_i && !(state_q == S_PC && chan_q)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            wp_q    <= wp_nxt;
            rp_q    <= wp_nxt;
            state_q <= S_SEED_RD;
          end
        end
        S_SEED_RD: begin
          rp_q    <= ptr_inc(rp_q);
          state_q <= S_SEED;
        end
        S_SEED: begin
          // Seed both filters with the oldest entry.
          b_q     <= lvl_t'(rd_data);
          t_q     <= lvl_t'(rd_data);
          cur_q   <= rd_data;
          tpend_q <= 1'b0;
          idx_q   <= RING_AW'(1);
          rp_q    <= ptr_inc(rp_q);
          state_q <= S_LD;
        end
        S_LD: begin
          // Retire the previous treble product while loading the next entry.
          if (tpend_q) begin
            t_q <= sat24(sum_t'(prod_rnd));
          end
          prev_q  <= cur_q;
          cur_q   <= rd_data;
          op_q    <= op_t'(rd_data) - op_t'(b_q);
          state_q <= S_MB;
        end
        S_MB: begin
          op_q    <= op_t'(t_q) + op_t'(cur_q) - op_t'(prev_q);
          rp_q    <= ptr_inc(rp_q);
          state_q <= S_MT;
        end
        S_MT: begin
          b_q     <= sat24(sum_t'(b_q) + sum_t'(prod_rnd));
          tpend_q <= 1'b1;
          if (idx_q == RING_AW'(RING_DEPTH - 1)) begin
            state_q <= S_TFIN;
          end else begin
            idx_q   <= idx_q + 1'b1;
            state_q <= S_LD;
          end
        end
        S_TFIN: begin
          t_q     <= sat24(sum_t'(prod_rnd));
          op_q    <= op_t'(bp_q);
          chan_q  <= 1'b0;
          state_q <= S_PD;
        end
        S_PD: begin
          state_q <= S_PR;
        end
        S_PR: begin
          if (chan_q) begin
            tp_q <= lvl_t'(prod_rnd);
          end else begin
            bp_q <= lvl_t'(prod_rnd);
          end
          op_q    <= op_t'(lvl_t'(prod_rnd));
          state_q <= S_PM;
        end
        S_PM: begin
          state_q <= S_PC;
        end
        S_PC: begin
          if (!chan_q) begin
            bbeat_q <= bwas_q && !pk;
            bwas_q  <= pk;
            if (pk) begin
              bp_q <= b_q;
            end
            chan_q  <= 1'b1;
            op_q    <= op_t'(tp_q);
            state_q <= S_PD;
          end else if (!out_valid_q || out_ready_i) begin
            // Hold here until the output register is free.
            out_bb_q    <= bbeat_q;
            out_tb_q    <= twas_q && !pk;
            out_bl_q    <= b_q;
            out_tl_q    <= t_q;
            out_valid_q <= 1'b1;
            twas_q      <= pk;
            if (pk) begin
              tp_q <= t_q;
            end
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_ready_o     = (state_q == S_IDLE);
  assign out_valid_o    = out_valid_q;
  assign bass_beat_o    = out_bb_q;
  assign treble_beat_o  = out_tb_q;
  assign bass_level_o   = out_bl_q;
  assign treble_level_o = out_tl_q;

endmodule

// ===== rtl/btbd_ring.sv =====
// Sample ring memory with registered read and a fill count for unwritten entries.
module btbd_ring
  import btbd_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic we_i,
  input  ptr_t waddr_i,
  input  smp_t wdata_i,
  input  logic re_i,
  input  ptr_t raddr_i,
  output smp_t rdata_o
);

  smp_t               mem [RING_DEPTH];
  smp_t               rdata_q;
  logic               rvalid_q;
  logic [RING_CW-1:0] cnt_q;

  // Entries are written in pointer order from zero, so index < count means written.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (we_i && cnt_q != RING_CW'(RING_DEPTH)) begin
        cnt_q <= cnt_q + 1'b1;
      end
      if (re_i) begin
        rvalid_q <= RING_CW'(raddr_i) < cnt_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rvalid_q ? rdata_q : '0;

endmodule

// ===== rtl/btbd_mul.sv =====
// Shared registered multiplier: signed operand times unsigned 16-bit coefficient.
module btbd_mul
  import btbd_pkg::*;
(
  input  logic        clk_i,
  input  op_t         a_i,
  input  logic [15:0] k_i,
  output prod_t       p_o
);

  logic signed [16:0] k_s;
  prod_t              p_q;

  assign k_s = $signed({1'b0, k_i});

  always_ff @(posedge clk_i) begin
    p_q <= prod_t'(a_i) * prod_t'(k_s);
  end

  assign p_o = p_q;

endmodule

// ===== rtl/btbd_cfg.sv =====
// APB register file for filter gain, peak decay and peak ratio.
module btbd_cfg
  import btbd_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output cfg_t               cfg_o
);

  cfg_t     cfg_q;
  cfg_idx_t idx;

  assign idx    = paddr[3:2];
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.filter_gain <= FILTER_GAIN_RST;
      cfg_q.peak_decay  <= PEAK_DECAY_RST;
      cfg_q.peak_ratio  <= PEAK_RATIO_RST;
    end else if (psel && penable && pwrite) begin
      unique case (idx)
        CFG_FILTER_GAIN: cfg_q.filter_gain <= pwdata[15:0];
        CFG_PEAK_DECAY:  cfg_q.peak_decay  <= pwdata[15:0];
        CFG_PEAK_RATIO:  cfg_q.peak_ratio  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      CFG_FILTER_GAIN: prdata = {16'd0, cfg_q.filter_gain};
      CFG_PEAK_DECAY:  prdata = {16'd0, cfg_q.peak_decay};
      CFG_PEAK_RATIO:  prdata = {16'd0, cfg_q.peak_ratio};
      default:         prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

// ===== dv/tb_bass_treble_beat_detector_top.sv =====
// Self-checking testbench for the bass/treble beat detector top level.
module tb_bass_treble_beat_detector_top;
  import btbd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY      = 3 * RING_DEPTH + 9;
  localparam int RAND_PER_SEG = 117;

  // Index past the last register: writes there must be dropped.
  localparam cfg_idx_t CFG_UNMAPPED = 2'd3;

  localparam logic [PADDR_W-1:0] ADDR_GAIN     = {CFG_FILTER_GAIN, 2'b00};
  localparam logic [PADDR_W-1:0] ADDR_DECAY    = {CFG_PEAK_DECAY, 2'b00};
  localparam logic [PADDR_W-1:0] ADDR_RATIO    = {CFG_PEAK_RATIO, 2'b00};
  localparam logic [PADDR_W-1:0] ADDR_UNMAPPED = {CFG_UNMAPPED, 2'b00};

  typedef struct packed {
    logic bass_beat;
    logic treble_beat;
    lvl_t bass_level;
    lvl_t treble_level;
  } beat_res_t;

  localparam beat_res_t ZERO_RES = '0;

  typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_e;

  typedef struct packed {
    row_kind_e          kind;
    logic [PADDR_W-1:0] addr;
    logic [31:0]        wdata;
    smp_t               smp;
    logic               typed;
    beat_res_t          res;
  } dir_row_t;

  localparam int DIR_ROWS = 32;

  // Zero samples out of reset give all-zero levels and no beats.
  dir_row_t dir_tbl [DIR_ROWS] = '{
    '{ROW_SAMPLE, ADDR_GAIN, 32'h0, 16'sd0, 1'b1, ZERO_RES},
    '{ROW_SAMPLE, ADDR_GAIN, 32'h0, 16'sd0, 1'b1, ZERO_RES},
    '{ROW_SAMPLE, ADDR_GAIN, 32'h0, 16'sh7FFF, 1'b0, ZERO_RES},
    '{ROW_SAMPLE, ADDR_GAIN, 32'h0, 16'sh7FFF, 1'b0, ZERO_RES},
    '{ROW_SAMPLE, ADDR_GAIN, 32'h0, 16'sh8000, 1'b0, ZERO_RES},
    '{ROW_SAMPLE, ADDR_GAIN, 32'h0, 16'sh8000, 1'b0, ZERO_RES},
    '{ROW_SAMPLE, ADDR_GAIN, 32'h0, 16'sh7FFF, 1'b0, ZERO_RES},
    '{ROW_SAMPLE, ADDR_GAIN, 32'h0, 16'sh8000, 1'b0, ZERO_RES},
    '{ROW_SAMPLE, ADDR_GAIN, 32'h0, 16'sd0, 1'b0, ZERO_RES},
    '{ROW_WRITE, ADDR_RATIO, 32'h0, 16'sd0, 1'b0, ZERO_RES},
    '{ROW_SAMPLE, ADDR_GAIN, 32'h0, 16'sd1000, 1'b0, ZERO_RES},
    '{ROW_SAMPLE, ADDR_GAIN, 32'h0, 16'sd2000, 1'b0, ZERO_RES},
    '{ROW_SAMPLE, ADDR_GAIN, 32'h0, -16'sd5000, 1'b0, ZERO_RES},
    '{ROW_SAMPLE, ADDR_GAIN, 32'h0, 16'sd7, 1'b0, ZERO_RES},
    '{ROW_WRITE, ADDR_GAIN, 32'h0, 16'sd0, 1'b0, ZERO_RES},
    '{ROW_SAMPLE, ADDR_GAIN, 32'h0, 16'sd100, 1'b0, ZERO_RES},
    '{ROW_SAMPLE, ADDR_GAIN, 32'h0, -16'sd100, 1'b0, ZERO_RES},
    '{ROW_WRITE, ADDR_GAIN, 32'h0000_FFFF, 16'sd0, 1'b0, ZERO_RES},
    '{ROW_WRITE, ADDR_DECAY, 32'h0, 16'sd0, 1'b0, ZERO_RES},
    '{ROW_WRITE, ADDR_RATIO, 32'h0000_FFFF, 16'sd0, 1'b0, ZERO_RES},
    '{ROW_SAMPLE, ADDR_GAIN, 32'h0, 16'sh7FFF, 1'b0, ZERO_RES},
    '{ROW_SAMPLE, ADDR_GAIN, 32'h0, 16'sh8000, 1'b0, ZERO_RES},
    '{ROW_SAMPLE, ADDR_GAIN, 32'h0, 16'sd12345, 1'b0, ZERO_RES},
    '{ROW_WRITE, ADDR_UNMAPPED, 32'hFFFF_FFFF, 16'sd0, 1'b0, ZERO_RES},
    '{ROW_SAMPLE, ADDR_GAIN, 32'h0, -16'sd1, 1'b0, ZERO_RES},
    '{ROW_WRITE, ADDR_DECAY, 32'hFFFF_FFFF, 16'sd0, 1'b0, ZERO_RES},
    '{ROW_SAMPLE, ADDR_GAIN, 32'h0, 16'sd30000, 1'b0, ZERO_RES},
    '{ROW_SAMPLE, ADDR_GAIN, 32'h0, 16'sd0, 1'b0, ZERO_RES},
    '{ROW_WRITE, ADDR_GAIN, {16'hFFFF, FILTER_GAIN_RST}, 16'sd0, 1'b0, ZERO_RES},
    '{ROW_WRITE, ADDR_DECAY, {16'h5A5A, PEAK_DECAY_RST}, 16'sd0, 1'b0, ZERO_RES},
    '{ROW_WRITE, ADDR_RATIO, {16'hA5A5, PEAK_RATIO_RST}, 16'sd0, 1'b0, ZERO_RES},
    '{ROW_SAMPLE, ADDR_GAIN, 32'h0, -16'sd20000, 1'b0, ZERO_RES}
  };

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  smp_t               sample_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic               bass_beat_o;
  logic               treble_beat_o;
  lvl_t               bass_level_o;
  lvl_t               treble_level_o;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  bass_treble_beat_detector_top i_dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .sample_i,
    .out_valid_o,
    .out_ready_i,
    .bass_beat_o,
    .treble_beat_o,
    .bass_level_o,
    .treble_level_o,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready
  );

  // Predictor state and register copies.
  smp_t        ring_q [RING_DEPTH] = '{default: '0};
  ptr_t        wr_ptr = '0;
  longint      bass_pk_lvl = 0;
  longint      treble_pk_lvl = 0;
  bit          bass_was_pk = 1'b0;
  bit          treble_was_pk = 1'b0;
  logic [15:0] gain_q = FILTER_GAIN_RST;
  logic [15:0] decay_q = PEAK_DECAY_RST;
  logic [15:0] ratio_q = PEAK_RATIO_RST;

  beat_res_t   pending_beats [$];
  int unsigned mismatch_cnt = 0;
  int unsigned snd_idle_pct;
  int unsigned rcv_idle_pct;
  int unsigned pulse_period = 4;
  int unsigned pulse_phase = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("bass_treble_beat_detector_top verification failed");
    $finish;
  end

  // Round to nearest, halves up; >>> floors a signed value.
  function automatic longint q16_round(longint v);
    return (v + 64'sd32768) >>> 16;
  endfunction

  function automatic longint clamp_lvl(longint v);
    if (v > 64'sd8388607) begin
      return 64'sd8388607;
    end else if (v < -64'sd8388608) begin
      return -64'sd8388608;
    end
    return v;
  endfunction

  function automatic beat_res_t predict_beats(smp_t x);
    longint    b, t, cur, prv;
    ptr_t      j, jp;
    bit        bpk, tpk;
    beat_res_t r;
    ring_q[wr_ptr] = x;
    wr_ptr = wr_ptr + 1'b1;
    // Seed with the oldest entry, then filter oldest to newest.
    b = ring_q[wr_ptr];
    t = b;
    for (int i = 1; i < RING_DEPTH; i++) begin
      j   = wr_ptr + ptr_t'(i);
      jp  = j - 1'b1;
      cur = ring_q[j];
      prv = ring_q[jp];
      b = clamp_lvl(b + q16_round((cur - b) * longint'(gain_q)));
      t = clamp_lvl(q16_round((t + cur - prv) * longint'(gain_q)));
    end
    bass_pk_lvl = q16_round(bass_pk_lvl * longint'(decay_q));
    bpk = (b * 4096) > (bass_pk_lvl * longint'(ratio_q));
    if (bpk) begin
      bass_pk_lvl = b;
    end
    treble_pk_lvl = q16_round(treble_pk_lvl * longint'(decay_q));
    tpk = (t * 4096) > (treble_pk_lvl * longint'(ratio_q));
    if (tpk) begin
      treble_pk_lvl = t;
    end
    r.bass_beat    = bass_was_pk && !bpk;
    r.treble_beat  = treble_was_pk && !tpk;
    r.bass_level   = lvl_t'(b);
    r.treble_level = lvl_t'(t);
    bass_was_pk   = bpk;
    treble_was_pk = tpk;
    return r;
  endfunction

  // Mostly a pulse train of loud hits over quiet noise, with extremes and full-range noise.
  function automatic smp_t next_sample();
    int unsigned sel;
    smp_t        s;
    sel = $urandom_range(0, 9);
    if (sel < 7) begin
      pulse_phase++;
      if (pulse_phase >= pulse_period) begin
        pulse_phase = 0;
        s = smp_t'($urandom_range(12000, 32767));
        if ($urandom_range(0, 1) == 1) begin
          s = -s;
        end
      end else begin
        s = smp_t'($urandom_range(0, 600)) - 16'sd300;
      end
    end else if (sel == 7) begin
      s = ($urandom_range(0, 1) == 1) ? 16'sh7FFF : 16'sh8000;
    end else begin
      s = smp_t'($urandom);
    end
    return s;
  endfunction

  function automatic logic [15:0] pick_reg(logic [15:0] dflt);
    case ($urandom_range(0, 5))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return dflt;
      default: return 16'($urandom);
    endcase
  endfunction

  // Called at a falling edge; returns at the falling edge after the transaction.
  task automatic send_sample(smp_t x, logic typed, beat_res_t res);
    beat_res_t pred;
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    sample_i   = x;
    do @(posedge clk_i); while (!in_ready_o);
    pred = predict_beats(x);
    pending_beats.push_back(typed ? res : pred);
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    in_valid_i = 1'b0;
    while (pending_beats.size() != 0) @(negedge clk_i);
  endtask

  task automatic apb_access(logic wr, logic [PADDR_W-1:0] addr, logic [31:0] data,
                            output logic [31:0] rd);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = wr;
    paddr   = addr;
    pwdata  = data;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    rd = prdata;
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  task automatic write_reg(logic [PADDR_W-1:0] addr, logic [31:0] data);
    logic [31:0] rd;
    logic [15:0] want;
    apb_access(1'b1, addr, data, rd);
    case (cfg_idx_t'(addr[PADDR_W-1:2]))
      CFG_FILTER_GAIN: gain_q = data[15:0];
      CFG_PEAK_DECAY:  decay_q = data[15:0];
      CFG_PEAK_RATIO:  ratio_q = data[15:0];
      default: ;
    endcase
    if (cfg_idx_t'(addr[PADDR_W-1:2]) != CFG_UNMAPPED) begin
      apb_access(1'b0, addr, 32'h0, rd);
      case (cfg_idx_t'(addr[PADDR_W-1:2]))
        CFG_FILTER_GAIN: want = gain_q;
        CFG_PEAK_DECAY:  want = decay_q;
        default:         want = ratio_q;
      endcase
      if (rd[15:0] !== want) begin
        $error("register readback at %0d: expected %0d, actual %0d", addr, want, rd[15:0]);
        mismatch_cnt++;
      end
    end
  endtask

  task automatic check_beats(beat_res_t got);
    beat_res_t want;
    if (pending_beats.size() == 0) begin
      $error("unexpected transaction: bass_level %0d treble_level %0d",
             got.bass_level, got.treble_level);
      mismatch_cnt++;
      return;
    end
    want = pending_beats.pop_front();
    if (got.bass_beat !== want.bass_beat) begin
      $error("bass_beat: expected %0d, actual %0d", want.bass_beat, got.bass_beat);
      mismatch_cnt++;
    end
    if (got.treble_beat !== want.treble_beat) begin
      $error("treble_beat: expected %0d, actual %0d", want.treble_beat, got.treble_beat);
      mismatch_cnt++;
    end
    if (got.bass_level !== want.bass_level) begin
      $error("bass_level: expected %0d, actual %0d", want.bass_level, got.bass_level);
      mismatch_cnt++;
    end
    if (got.treble_level !== want.treble_level) begin
      $error("treble_level: expected %0d, actual %0d", want.treble_level, got.treble_level);
      mismatch_cnt++;
    end
  endtask

  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      out_ready_i = ($urandom_range(0, 99) >= rcv_idle_pct);
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        check_beats('{bass_beat_o, treble_beat_o, bass_level_o, treble_level_o});
      end
    end
  end

  initial begin
    in_valid_i   = 1'b0;
    sample_i     = '0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    rst_ni       = 1'b0;
    snd_idle_pct = 14;
    rcv_idle_pct = 52;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (dir_tbl[k]) begin
      if (dir_tbl[k].kind == ROW_WRITE) begin
        wait_idle();
        write_reg(dir_tbl[k].addr, dir_tbl[k].wdata);
      end else begin
        send_sample(dir_tbl[k].smp, dir_tbl[k].typed, dir_tbl[k].res);
      end
    end

    for (int ph = 0; ph < 3; ph++) begin
      snd_idle_pct = (ph == 0) ? 14 : (ph == 1) ? 52 : 0;
      rcv_idle_pct = (ph == 0) ? 52 : (ph == 1) ? 14 : 0;
      for (int seg = 0; seg < 4; seg++) begin
        wait_idle();
        write_reg(ADDR_GAIN, {16'($urandom), pick_reg(FILTER_GAIN_RST)});
        write_reg(ADDR_DECAY, {16'($urandom), pick_reg(PEAK_DECAY_RST)});
        write_reg(ADDR_RATIO, {16'($urandom), pick_reg(PEAK_RATIO_RST)});
        pulse_period = $urandom_range(2, 12);
        pulse_phase  = 0;
        repeat (RAND_PER_SEG) send_sample(next_sample(), 1'b0, ZERO_RES);
      end
    end

    wait_idle();
    // Hold a while longer to catch any stray transaction.
    repeat (2 * LATENCY) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("bass_treble_beat_detector_top verification clean");
    end else begin
      $display("bass_treble_beat_detector_top verification failed");
    end
    $finish;
  end

endmodule
